[design/gspnh_pkg.sv]
// Shared command, status and code definitions for the grid next-hop block.
package gspnh_pkg;

  // Result status codes
  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_SAME    = 2'd1;
  localparam logic [1:0] ST_UNREACH = 2'd2;

  // Configuration register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic       latch;
    logic       edge_clr;
    logic       load_own;
    logic       load_mir;
    logic       node_clr;
    logic       q_init;
    logic       visit;
    logic       dir_clr;
    logic       relax_wr;
    logic       dir_inc;
    logic       scan_start;
    logic       scan_run;
    logic       adopt;
    logic       bt_init;
    logic       bt_rd;
    logic       bt_step;
    logic       res_load;
    logic [1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic q_oob;
    logic q_same;
    logic dir_last;
    logic scan_done;
    logic found;
    logic bt_hit;
    logic bt_miss;
    logic out_free;
  } stat_t;

endpackage

[design/grid_shortest_path_next_hop.sv]
// Top level of the grid shortest-path next-hop block.
//
// Input channel (in_valid/in_ready) carries one item: func 0 loads the edge
// weights of one cell (mirror also writes the neighbours' edges back toward
// it), func 1 asks for the first hop from the start cell toward the target.
// A load gives no result; it writes the cell's own edges, then, with mirror
// set, the mirror edges. A query gives one result on the output channel
// (out_valid/out_ready): next_x, next_y and status. A query is checked, then
// a pass clears the search memory of 2^(2*ceil(log2 MAX_SIDE)) words (1024
// at the defaults); then every visited cell is relaxed toward its neighbours
// and the grid is scanned for the next cell through the single read port of
// the search memory; then the path is walked back from the target, and the
// result register is loaded.
// One item is worked at a time; in_ready is high while the block is idle,
// and an item is taken while an earlier result still waits in the output
// register. A stalled receiver holds that result; a finished query then
// waits for the register to drain.
// After reset the edge memories are cleared with in_ready low; grid_width and
// grid_height reset to 20 and are written through cfg_we/cfg_index/cfg_data;
// the user writes them only while idle, which the block does not enforce.
module grid_shortest_path_next_hop #(
  parameter int MAX_SIDE    = 32,
  parameter int WEIGHT_BITS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [4:0]  cell_x,
  input  logic [4:0]  cell_y,
  input  logic [4:0]  target_x,
  input  logic [4:0]  target_y,
  input  logic [14:0] weight_left,
  input  logic [14:0] weight_right,
  input  logic [14:0] weight_up,
  input  logic [14:0] weight_down,
  input  logic        mirror,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  next_x,
  output logic [4:0]  next_y,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);

  gspnh_pkg::cmd_t  cmd;
  gspnh_pkg::stat_t stat;

  gspnh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  gspnh_dp #(
    .MAX_SIDE    (MAX_SIDE),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .func         (func),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .target_x     (target_x),
    .target_y     (target_y),
    .weight_left  (weight_left),
    .weight_right (weight_right),
    .weight_up    (weight_up),
    .weight_down  (weight_down),
    .mirror       (mirror),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .next_x       (next_x),
    .next_y       (next_y),
    .status       (status),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

[design/gspnh_ctrl.sv]
// Sequencer for loads, clearing passes, Dijkstra steps and backtracking.
module gspnh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              func,
  output logic              in_ready,
  output gspnh_pkg::cmd_t   cmd,
  input  gspnh_pkg::stat_t  stat
);

  typedef enum logic [12:0] {
    S_RSTCLR = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_LDOWN  = 13'b0000000000100,
    S_LDMIR  = 13'b0000000001000,
    S_QCHK   = 13'b0000000010000,
    S_CLR    = 13'b0000000100000,
    S_VISIT  = 13'b0000001000000,
    S_RRD    = 13'b0000010000000,
    S_RWR    = 13'b0000100000000,
    S_SCAN   = 13'b0001000000000,
    S_BTRD   = 13'b0010000000000,
    S_BTCHK  = 13'b0100000000000,
    S_RESULT = 13'b1000000000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] res_code, res_code_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    state_next    = state;
    res_code_next = res_code;
    cmd.res_status = res_code;
    unique case (state)
      S_RSTCLR: begin
        cmd.edge_clr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = func ? S_QCHK : S_LDOWN;
        end
      end
      S_LDOWN: begin
        cmd.load_own = 1'b1;
        state_next   = S_LDMIR;
      end
      S_LDMIR: begin
        cmd.load_mir = 1'b1;
        state_next   = S_IDLE;
      end
      S_QCHK: begin
        if (stat.q_oob) begin
          res_code_next = gspnh_pkg::ST_UNREACH;
          state_next    = S_RESULT;
        end else if (stat.q_same) begin
          res_code_next = gspnh_pkg::ST_SAME;
          state_next    = S_RESULT;
        end else begin
          cmd.q_init = 1'b1;
          state_next = S_CLR;
        end
      end
      S_CLR: begin
        cmd.node_clr = 1'b1;
        if (stat.clr_last) state_next = S_VISIT;
      end
      S_VISIT: begin
        cmd.visit   = 1'b1;
        cmd.dir_clr = 1'b1;
        state_next  = S_RRD;
      end
      S_RRD: state_next = S_RWR;
      S_RWR: begin
        cmd.relax_wr = 1'b1;
        if (stat.dir_last) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          cmd.dir_inc = 1'b1;
          state_next  = S_RRD;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          if (stat.found) begin
            cmd.adopt  = 1'b1;
            state_next = S_VISIT;
          end else begin
            cmd.bt_init = 1'b1;
            state_next  = S_BTRD;
          end
        end
      end
      S_BTRD: begin
        cmd.bt_rd  = 1'b1;
        state_next = S_BTCHK;
      end
      S_BTCHK: begin
        if (stat.bt_miss) begin
          res_code_next = gspnh_pkg::ST_UNREACH;
          state_next    = S_RESULT;
        end else if (stat.bt_hit) begin
          res_code_next = gspnh_pkg::ST_FOUND;
          state_next    = S_RESULT;
        end else begin
          cmd.bt_step = 1'b1;
          state_next  = S_BTRD;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_RSTCLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RSTCLR;
      res_code <= gspnh_pkg::ST_FOUND;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
    end
  end

  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> stat.out_free)
    else $error("result loaded while output register busy");

  a_query_chk: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func) |=> (state == S_QCHK))
    else $error("query transfer did not enter checking");

  a_scan_next: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && stat.scan_done && stat.found) |=> (state == S_VISIT))
    else $error("found cell not visited");

  a_load_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_LDOWN) |=> (state == S_LDMIR))
    else $error("load skipped mirror phase");

endmodule

[design/gspnh_dp.sv]
// Datapath: edge memories, per-cell search memory, scan and backtrack registers.
module gspnh_dp #(
  parameter int MAX_SIDE    = 32,
  parameter int WEIGHT_BITS = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              func,
  input  logic [4:0]        cell_x,
  input  logic [4:0]        cell_y,
  input  logic [4:0]        target_x,
  input  logic [4:0]        target_y,
  input  logic [14:0]       weight_left,
  input  logic [14:0]       weight_right,
  input  logic [14:0]       weight_up,
  input  logic [14:0]       weight_down,
  input  logic              mirror,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [5:0]        cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [4:0]        next_x,
  output logic [4:0]        next_y,
  output logic [1:0]        status,
  input  gspnh_pkg::cmd_t   cmd,
  output gspnh_pkg::stat_t  stat
);

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int WB    = WEIGHT_BITS;
  localparam int CB    = WB + AW;
  localparam int NW    = 2 + CB + AW;
  localparam int LW    = SW + CW + 6;

  logic [5:0]    gw, gh;
  logic [SW-1:0] w_side, h_side;
  logic [LW-1:0] gw_l, gh_l;

  logic          func_q, mir_q;
  logic [4:0]    x_q, y_q, tx_q, ty_q;
  logic [WB-1:0] wt_q [4];

  logic [CW-1:0] cx, cy;
  logic [CB-1:0] cur_cost;
  logic [AW-1:0] cur_prev, s_addr, bt_cur;
  logic [1:0]    dir;
  logic [AW-1:0] clr_cnt;

  logic          nbin [4];
  logic [AW-1:0] nb_addr [4];
  logic [WB:0]   edge_rd [4];
  logic          load_ok;

  logic [NW-1:0] node_mem [DEPTH];
  logic [NW-1:0] nd;
  logic          node_we;
  logic [AW-1:0] node_waddr, node_raddr;
  logic [NW-1:0] node_wdata;
  logic          nd_vis, nd_val;
  logic [CB-1:0] nd_cost;
  logic [AW-1:0] nd_prev;

  logic [WB:0]   rel_edge;
  logic [CB-1:0] cand;
  logic          relax_ok;

  logic [CW-1:0] scx, scy;
  logic          sc_v, issue_done, found;
  logic          sc_lastx, sc_lasty;
  logic [CB-1:0] best;
  logic [AW-1:0] best_addr, best_prev;
  logic [AW-1:0] node_addr_q;

  logic [CW+4:0] ext_x, ext_y, ext_tx, ext_ty;
  logic [CW+4:0] res_xe, res_ye;

  function automatic logic [WB-1:0] wfit(input logic [14:0] v);
    logic [WB+14:0] t;
    t = {{WB{1'b0}}, v};
    return t[WB-1:0];
  endfunction

  // clamp the grid size registers to 1..MAX_SIDE
  always_comb begin
    gw_l = LW'(gw);
    gh_l = LW'(gh);
    if (gw_l == '0) w_side = SW'(1);
    else if (gw_l > LW'(MAX_SIDE)) w_side = SW'(MAX_SIDE);
    else w_side = gw_l[SW-1:0];
    if (gh_l == '0) h_side = SW'(1);
    else if (gh_l > LW'(MAX_SIDE)) h_side = SW'(MAX_SIDE);
    else h_side = gh_l[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gw <= 6'd20;
      gh <= 6'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        gspnh_pkg::REG_GRID_WIDTH:  gw <= cfg_data;
        gspnh_pkg::REG_GRID_HEIGHT: gh <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ext_x  = {{CW{1'b0}}, cell_x};
  assign ext_y  = {{CW{1'b0}}, cell_y};
  assign ext_tx = {{CW{1'b0}}, tx_q};
  assign ext_ty = {{CW{1'b0}}, ty_q};

  assign load_ok = (LW'(x_q) < LW'(w_side)) && (LW'(y_q) < LW'(h_side));

  assign stat.q_oob = !(load_ok && (LW'(tx_q) < LW'(w_side))
                        && (LW'(ty_q) < LW'(h_side)));
  assign stat.q_same = (x_q == tx_q) && (y_q == ty_q);

  // neighbours of the current cell: left, right, up, down
  always_comb begin
    nbin[0]    = (cx != '0);
    nb_addr[0] = {cy, cx - CW'(1)};
    nbin[1]    = (LW'(cx) + LW'(1)) < LW'(w_side);
    nb_addr[1] = {cy, cx + CW'(1)};
    nbin[2]    = (cy != '0);
    nb_addr[2] = {cy - CW'(1), cx};
    nbin[3]    = (LW'(cy) + LW'(1)) < LW'(h_side);
    nb_addr[3] = {cy + CW'(1), cx};
  end

  for (genvar e = 0; e < 4; e++) begin : g_edge
    localparam int F = e ^ 1;
    logic [WB:0]   mem [DEPTH];
    logic [WB:0]   rd_q, wdata;
    logic [AW-1:0] waddr;
    logic          we;

    always_comb begin
      we    = 1'b0;
      waddr = clr_cnt;
      wdata = '0;
      if (cmd.edge_clr) begin
        we = 1'b1;
      end else if (cmd.load_own) begin
        we    = load_ok && nbin[e];
        waddr = {cy, cx};
        wdata = {1'b1, wt_q[e]};
      end else if (cmd.load_mir) begin
        // mirror edge lands on the neighbour in the opposite direction
        we    = load_ok && mir_q && nbin[F];
        waddr = nb_addr[F];
        wdata = {1'b1, wt_q[F]};
      end
    end

    always_ff @(posedge clk) begin
      if (we) mem[waddr] <= wdata;
      rd_q <= mem[nb_addr[F]];
    end

    assign edge_rd[e] = rd_q;
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.edge_clr || cmd.node_clr) clr_cnt <= clr_cnt + AW'(1);
  end
  assign stat.clr_last = (clr_cnt == {AW{1'b1}});

  // search node word: visited, reached, cost, predecessor
  assign nd_vis  = nd[NW-1];
  assign nd_val  = nd[NW-2];
  assign nd_cost = nd[NW-3 -: CB];
  assign nd_prev = nd[AW-1:0];

  assign rel_edge = edge_rd[dir ^ 2'd1];
  assign cand     = cur_cost + CB'(rel_edge[WB-1:0]);
  assign relax_ok = nbin[dir] && !nd_vis && rel_edge[WB]
                    && (!nd_val || (cand < nd_cost));

  always_comb begin
    node_we    = 1'b0;
    node_waddr = clr_cnt;
    node_wdata = '0;
    if (cmd.node_clr) begin
      node_we = 1'b1;
    end else if (cmd.visit) begin
      node_we    = 1'b1;
      node_waddr = {cy, cx};
      node_wdata = {1'b1, 1'b1, cur_cost, cur_prev};
    end else if (cmd.relax_wr && relax_ok) begin
      node_we    = 1'b1;
      node_waddr = nb_addr[dir];
      node_wdata = {1'b0, 1'b1, cand, cy, cx};
    end
    if (cmd.scan_run) node_raddr = {scy, scx};
    else if (cmd.bt_rd) node_raddr = bt_cur;
    else node_raddr = nb_addr[dir];
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    nd <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q <= func;
      mir_q  <= mirror;
      x_q    <= cell_x;
      y_q    <= cell_y;
      tx_q   <= target_x;
      ty_q   <= target_y;
      wt_q[0] <= wfit(weight_left);
      wt_q[1] <= wfit(weight_right);
      wt_q[2] <= wfit(weight_up);
      wt_q[3] <= wfit(weight_down);
      cx     <= ext_x[CW-1:0];
      cy     <= ext_y[CW-1:0];
      s_addr <= {ext_y[CW-1:0], ext_x[CW-1:0]};
    end
    if (cmd.q_init) begin
      cur_cost <= '0;
      cur_prev <= '0;
    end
    if (cmd.adopt) begin
      cx       <= best_addr[CW-1:0];
      cy       <= best_addr[AW-1:CW];
      cur_cost <= best;
      cur_prev <= best_prev;
    end
    if (cmd.dir_clr) dir <= 2'd0;
    else if (cmd.dir_inc) dir <= dir + 2'd1;
    if (cmd.bt_init) bt_cur <= {ext_ty[CW-1:0], ext_tx[CW-1:0]};
    else if (cmd.bt_step) bt_cur <= nd_prev;
  end

  assign stat.dir_last = (dir == 2'd3);
  assign stat.bt_hit   = (nd_prev == s_addr);
  assign stat.bt_miss  = !nd_val;

  // x-major scan for the cheapest reached, unvisited cell
  assign sc_lastx = (LW'(scx) + LW'(1)) == LW'(w_side);
  assign sc_lasty = (LW'(scy) + LW'(1)) == LW'(h_side);

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_v       <= 1'b0;
      issue_done <= 1'b0;
      found      <= 1'b0;
    end else if (cmd.scan_start) begin
      sc_v       <= 1'b0;
      issue_done <= 1'b0;
      found      <= 1'b0;
      scx        <= '0;
      scy        <= '0;
    end else if (cmd.scan_run) begin
      sc_v <= !issue_done;
      if (!issue_done) begin
        if (sc_lasty) begin
          scy <= '0;
          scx <= scx + CW'(1);
          if (sc_lastx) issue_done <= 1'b1;
        end else begin
          scy <= scy + CW'(1);
        end
      end
      if (sc_v && !nd_vis && nd_val && (!found || (nd_cost < best))) begin
        found     <= 1'b1;
        best      <= nd_cost;
        best_prev <= nd_prev;
        best_addr <= node_addr_q;
      end
    end
  end

  // address of the word now in the read register
  always_ff @(posedge clk) node_addr_q <= node_raddr;

  assign stat.scan_done = issue_done && !sc_v;
  assign stat.found     = found;

  // result register
  assign res_xe = {5'd0, bt_cur[CW-1:0]};
  assign res_ye = {5'd0, bt_cur[AW-1:CW]};
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.res_load) begin
      status <= cmd.res_status;
      if (cmd.res_status == gspnh_pkg::ST_FOUND && func_q) begin
        next_x <= res_xe[4:0];
        next_y <= res_ye[4:0];
      end else begin
        next_x <= 5'd0;
        next_y <= 5'd0;
      end
    end
  end

endmodule

[bench/grid_shortest_path_next_hop_tb.sv]
// Self-checking testbench for the grid shortest-path next-hop block.
module grid_shortest_path_next_hop_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE       = 32;
  localparam int CELL_COUNT = SIDE * SIDE;
  localparam int IDLE_LIMIT = 5000000;
  localparam int LONG_HOLD  = 20000;

  localparam bit FUNC_LOAD  = 1'b0;
  localparam bit FUNC_QUERY = 1'b1;

  // Edge directions; d ^ 1 is the opposite direction
  localparam int DIR_LEFT  = 0;
  localparam int DIR_RIGHT = 1;
  localparam int DIR_UP    = 2;
  localparam int DIR_DOWN  = 3;

  typedef struct {
    bit        func;
    bit [4:0]  cx, cy, tx, ty;
    bit [14:0] wt[4];
    bit        mirror;
  } hop_item_t;

  typedef struct {
    bit [4:0] nx, ny;
    bit [1:0] st;
  } hop_result_t;

  class hop_scoreboard;
    bit          has_edge[CELL_COUNT][4];
    bit [14:0]   edge_wt[CELL_COUNT][4];
    int          cols = 20, rows = 20;
    hop_result_t hops_due[$];
    int          errors = 0;

    function void set_size(bit idx, bit [5:0] v);
      int side;
      side = (v == 0) ? 1 : (v > SIDE) ? SIDE : v;
      if (idx == gspnh_pkg::REG_GRID_WIDTH) cols = side;
      else rows = side;
    endfunction

    function bit step_to(int x, int y, int d, output int nx, output int ny);
      nx = x;
      ny = y;
      case (d)
        DIR_LEFT:  begin if (x == 0) return 0; nx = x - 1; end
        DIR_RIGHT: begin if (x + 1 >= cols) return 0; nx = x + 1; end
        DIR_UP:    begin if (y == 0) return 0; ny = y - 1; end
        default:   begin if (y + 1 >= rows) return 0; ny = y + 1; end
      endcase
      return 1;
    endfunction

    function void push(int nx, int ny, bit [1:0] st);
      hop_result_t r;
      r.nx = nx[4:0];
      r.ny = ny[4:0];
      r.st = st;
      hops_due.insert(hops_due.size(), r);
    endfunction

    function int pending();
      return hops_due.size();
    endfunction

    function void note_input(hop_item_t it);
      longint unsigned cost[CELL_COUNT];
      bit              reached[CELL_COUNT];
      bit              seen[CELL_COUNT];
      int              prev[CELL_COUNT];
      longint unsigned cand, best;
      int              x, y, nx, ny, c, n, s, t, cur, bx, by;
      bit              found, done;
      if (it.func == FUNC_LOAD) begin
        if (it.cx >= cols || it.cy >= rows) return;
        c = it.cy * SIDE + it.cx;
        for (int d = 0; d < 4; d++) begin
          if (!step_to(it.cx, it.cy, d, nx, ny)) continue;
          has_edge[c][d] = 1;
          edge_wt[c][d] = it.wt[d];
          if (it.mirror) begin
            n = ny * SIDE + nx;
            has_edge[n][d ^ 1] = 1;
            edge_wt[n][d ^ 1] = it.wt[d];
          end
        end
        return;
      end
      if (it.cx >= cols || it.cy >= rows || it.tx >= cols || it.ty >= rows) begin
        push(0, 0, gspnh_pkg::ST_UNREACH);
        return;
      end
      if (it.cx == it.tx && it.cy == it.ty) begin
        push(0, 0, gspnh_pkg::ST_SAME);
        return;
      end
      for (int i = 0; i < CELL_COUNT; i++) begin
        cost[i] = 0;
        reached[i] = 0;
        seen[i] = 0;
        prev[i] = 0;
      end
      s = it.cy * SIDE + it.cx;
      reached[s] = 1;
      x = it.cx;
      y = it.cy;
      forever begin
        c = y * SIDE + x;
        seen[c] = 1;
        // cost of a hop is the neighbor's own edge back toward this cell
        for (int d = 0; d < 4; d++) begin
          if (!step_to(x, y, d, nx, ny)) continue;
          n = ny * SIDE + nx;
          if (seen[n] || !has_edge[n][d ^ 1]) continue;
          cand = cost[c] + edge_wt[n][d ^ 1];
          if (!reached[n] || cand < cost[n]) begin
            reached[n] = 1;
            cost[n] = cand;
            prev[n] = c;
          end
        end
        found = 0;
        best = 0;
        bx = 0;
        by = 0;
        for (int sx = 0; sx < cols; sx++)
          for (int sy = 0; sy < rows; sy++) begin
            n = sy * SIDE + sx;
            if (seen[n] || !reached[n]) continue;
            if (!found || cost[n] < best) begin
              found = 1;
              best = cost[n];
              bx = sx;
              by = sy;
            end
          end
        if (!found) break;
        x = bx;
        y = by;
      end
      t = it.ty * SIDE + it.tx;
      done = 0;
      if (reached[t]) begin
        cur = t;
        for (int k = 0; k < cols * rows; k++) begin
          if (prev[cur] == s) begin
            push(cur % SIDE, cur / SIDE, gspnh_pkg::ST_FOUND);
            done = 1;
            break;
          end
          cur = prev[cur];
        end
      end
      if (!done) push(0, 0, gspnh_pkg::ST_UNREACH);
    endfunction

    function void check_result(bit [4:0] nx, bit [4:0] ny, bit [1:0] st);
      hop_result_t e;
      if (hops_due.size() == 0) begin
        $error("result with no query outstanding: next_x %0d next_y %0d status %0d",
               nx, ny, st);
        errors++;
        return;
      end
      e = hops_due.pop_front();
      if (nx !== e.nx) begin
        $error("next_x expected %0d actual %0d", e.nx, nx);
        errors++;
      end
      if (ny !== e.ny) begin
        $error("next_y expected %0d actual %0d", e.ny, ny);
        errors++;
      end
      if (st !== e.st) begin
        $error("status expected %0d actual %0d", e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FUNC_LOAD;
  logic [4:0]  cell_x = '0, cell_y = '0, target_x = '0, target_y = '0;
  logic [14:0] weight_left = '0, weight_right = '0, weight_up = '0, weight_down = '0;
  logic        mirror = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  next_x, next_y;
  logic [1:0]  status;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [5:0]  cfg_data = '0;

  hop_scoreboard sb = new();
  int            hold_requests = 0;
  int            idle_cycles = 0;

  grid_shortest_path_next_hop u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .cell_x(cell_x), .cell_y(cell_y),
    .target_x(target_x), .target_y(target_y),
    .weight_left(weight_left), .weight_right(weight_right),
    .weight_up(weight_up), .weight_down(weight_down), .mirror(mirror),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_x(next_x), .next_y(next_y), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Transfer monitor
  always @(posedge clk) begin
    hop_item_t it;
    if (!rst && in_valid && in_ready) begin
      it.func = func;
      it.cx = cell_x;
      it.cy = cell_y;
      it.tx = target_x;
      it.ty = target_y;
      it.wt[DIR_LEFT] = weight_left;
      it.wt[DIR_RIGHT] = weight_right;
      it.wt[DIR_UP] = weight_up;
      it.wt[DIR_DOWN] = weight_down;
      it.mirror = mirror;
      sb.note_input(it);
    end
    if (!rst && out_valid && out_ready) sb.check_result(next_x, next_y, status);
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("grid_shortest_path_next_hop_tb NOT OK");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold on request
  always @(posedge clk) begin
    int hold_left;
    int holds_done;
    int r;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      holds_done = 0;
    end else if (holds_done != hold_requests) begin
      holds_done = hold_requests;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        hold_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 80);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic bit [14:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return 15'($urandom_range(0, 3));
      1: return 15'h7fff - 15'($urandom_range(0, 3));
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic hop_item_t make_load(int x, int y, bit mir);
    hop_item_t it;
    it.func = FUNC_LOAD;
    it.cx = 5'(x);
    it.cy = 5'(y);
    it.tx = 5'($urandom_range(0, 31));
    it.ty = 5'($urandom_range(0, 31));
    for (int d = 0; d < 4; d++) it.wt[d] = pick_weight();
    it.mirror = mir;
    return it;
  endfunction

  function automatic hop_item_t make_query(int sx, int sy, int tx, int ty);
    hop_item_t it;
    it = make_load(sx, sy, 1'($urandom_range(0, 1)));
    it.func = FUNC_QUERY;
    it.tx = 5'(tx);
    it.ty = 5'(ty);
    return it;
  endfunction

  function automatic int pick_coord(int span);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, span - 1);
    return $urandom_range(0, 31);
  endfunction

  task automatic send(hop_item_t it);
    int gap;
    func <= it.func;
    cell_x <= it.cx;
    cell_y <= it.cy;
    target_x <= it.tx;
    target_y <= it.ty;
    weight_left <= it.wt[DIR_LEFT];
    weight_right <= it.wt[DIR_RIGHT];
    weight_up <= it.wt[DIR_UP];
    weight_down <= it.wt[DIR_DOWN];
    mirror <= it.mirror;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // loads finish silently; give the last one time to land
    repeat (60) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic set_grid(bit [5:0] w, bit [5:0] h);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= gspnh_pkg::REG_GRID_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    sb.set_size(gspnh_pkg::REG_GRID_WIDTH, w);
    cfg_index <= gspnh_pkg::REG_GRID_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    sb.set_size(gspnh_pkg::REG_GRID_HEIGHT, h);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 65)
        send(make_load(pick_coord(sb.cols), pick_coord(sb.rows), $urandom_range(0, 3) != 0));
      else
        send(make_query(pick_coord(sb.cols), pick_coord(sb.rows),
                        pick_coord(sb.cols), pick_coord(sb.rows)));
    end
  endtask

  initial begin
    hop_item_t it;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_grid(4, 4);
    send(make_query(0, 0, 3, 3));     // nothing loaded yet: unreachable
    send(make_query(1, 1, 1, 1));     // target equals start
    send(make_query(0, 0, 5, 0));     // target outside grid
    send(make_query(31, 31, 0, 0));   // start outside grid
    send(make_load(31, 0, 1));        // load outside grid: dropped
    it = make_load(0, 0, 1);
    it.wt[DIR_LEFT] = 15'h7fff;       // off grid, dropped
    it.wt[DIR_RIGHT] = 15'h0000;
    it.wt[DIR_DOWN] = 15'h7fff;
    send(it);
    send(make_load(1, 0, 1));
    send(make_load(2, 0, 1));
    send(make_load(3, 0, 1));
    send(make_load(3, 1, 1));
    send(make_load(3, 2, 1));
    send(make_load(3, 3, 1));
    it = make_load(1, 1, 0);
    for (int d = 0; d < 4; d++) it.wt[d] = 15'h7fff;
    send(it);
    send(make_query(0, 0, 3, 3));
    send(make_query(3, 3, 0, 0));
    send(make_query(0, 0, 1, 1));
    send(make_query(2, 0, 0, 3));
    send(make_query(3, 1, 1, 0));

    // width 0 clamps to one column, height 63 to the full side
    set_grid(0, 63);
    for (int i = 0; i < 8; i++) send(make_load(0, $urandom_range(0, 31), 1));
    send(make_query(0, 0, 0, 31));
    send(make_query(0, 31, 0, $urandom_range(0, 30)));
    send(make_query(1, 0, 0, 3));

    set_grid(63, 1);
    for (int i = 0; i < 6; i++) send(make_load($urandom_range(0, 31), 0, 1));
    send(make_query(31, 0, 0, 0));
    send(make_query(0, 0, 31, 0));

    // full grid: stored edges lie only along row 0, column 0 and the 4x4 corner
    set_grid(32, 32);
    send(make_query(0, 0, 3, 3));
    send(make_query(31, 31, 30, 31));
    send(make_query(2, 0, 31, 0));

    set_grid(6'($urandom_range(3, 8)), 6'($urandom_range(3, 8)));
    random_phase(20);
    // long receiver hold while queries keep coming
    hold_requests++;
    for (int i = 0; i < 8; i++)
      send(make_query($urandom_range(0, sb.cols - 1), $urandom_range(0, sb.rows - 1),
                      $urandom_range(0, sb.cols - 1), $urandom_range(0, sb.rows - 1)));
    set_grid(6'($urandom_range(1, 6)), 6'($urandom_range(1, 6)));
    random_phase(15);
    set_grid(32, 32);
    random_phase(15);
    set_grid(6'($urandom_range(2, 8)), 6'($urandom_range(2, 8)));
    random_phase(10);

    wait_idle();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("grid_shortest_path_next_hop_tb OK");
    else $display("grid_shortest_path_next_hop_tb NOT OK");
    $finish;
  end

endmodule

[grid_shortest_path_next_hop.f]
design/gspnh_pkg.sv
design/gspnh_ctrl.sv
design/gspnh_dp.sv
design/grid_shortest_path_next_hop.sv
bench/grid_shortest_path_next_hop_tb.sv
